// ===== rtl/core/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types and constants for the utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned TakenW = 2;

  // code units
  localparam logic [WordW-1:0] ReplacementWord = 16'hFFFD;
  localparam logic [WordW-1:0] EndWord         = 16'h0000;
  localparam logic [5:0]       HighSurrTag     = 6'b110110;
  localparam logic [5:0]       LowSurrTag      = 6'b110111;

  // code point limits
  localparam logic [CpW-1:0] MinTwoByte   = 21'h000080;
  localparam logic [CpW-1:0] MinThreeByte = 21'h000800;
  localparam logic [CpW-1:0] MinFourByte  = 21'h010000;
  localparam logic [CpW-1:0] MaxCodePoint = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrFirst    = 21'h00D800;
  localparam logic [CpW-1:0] SurrLast     = 21'h00DFFF;
  localparam logic [CpW-1:0] NonCharA     = 21'h00FFFE;
  localparam logic [CpW-1:0] NonCharB     = 21'h00FFFF;

  // sequence lengths
  localparam logic [LenW-1:0] LenNone  = 3'd0;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;

  // words produced by one request: a run of replacements, then up to two others
  typedef struct packed {
    logic [LenW-1:0]  nbad;
    logic [1:0]       ntail;
    logic [WordW-1:0] t0_word;
    logic             t0_bad;
    logic             t0_end;
    logic [WordW-1:0] t1_word;
  } bundle_t;

endpackage

// ===== rtl/core/utf8_to_utf16_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// byte-wide utf-8 decoder giving utf-16 code units with error replacement
// ----------------------------------------------------------------------------
// usage
//   input channel: one utf-8 byte per request on text_byte_i, taken when
//   in_valid_i is high and in_stall_o is low. a zero byte ends the string.
//   output channel: one utf-16 word per request with bad_input_o,
//   string_end_o and last_of_item_o, taken when out_valid_o is high and
//   out_stall_i is low. a byte gives zero to four words.
//   path: an accepted byte passes the byte register, then the result register.
//   throughput: one byte per cycle while each byte gives at most one word
//   and out_stall_i is low; a byte giving several words holds the result
//   register until they are taken. the byte register takes one more byte meanwhile.
//   reset: clears the pending sequence and drops every word not yet taken.
//   receiver stall: the current word holds, the byte register fills, then
//   in_stall_o rises until the result register drains.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [u8u16_pkg::ByteW-1:0]   text_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [u8u16_pkg::WordW-1:0]   utf16_word_o,
  output logic                          bad_input_o,
  output logic                          string_end_o,
  output logic                          last_of_item_o
);
  import u8u16_pkg::*;

  // byte register
  logic             in_vld_q, in_vld_d;
  logic [ByteW-1:0] byte_q;
  logic             in_acc, adv, out_free, out_take;

  // decode state
  logic [LenW-1:0]   len_q, len_d;
  logic [TakenW-1:0] taken_q, taken_d;
  logic [CpW-1:0]    cp_q, cp_d;

  // result register
  bundle_t    bund_q, bund_d;
  logic [2:0] rem_q, rem_d;
  logic [1:0] pos_q, pos_d;

  // decode scratch
  logic              pending, is_cont, finishing, seq_bad;
  logic [TakenW-1:0] taken_inc;
  logic [CpW-1:0]    cp_new, cp_off;
  logic [LenW-1:0]   s_len;
  logic [CpW-1:0]    s_cp;
  logic              s_emit, s_bad, s_end;
  logic [WordW-1:0]  s_word;

  // handshakes: the byte register moves on once the result register is free
  assign out_take   = out_valid_o && !out_stall_i;
  assign out_free   = (rem_q == 3'd0) || ((rem_q == 3'd1) && !out_stall_i);
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= text_byte_i;
    end
  end

  // lead byte sizing, also used after a broken sequence
  always_comb begin
    s_len  = LenNone;
    s_cp   = '0;
    s_emit = 1'b0;
    s_bad  = 1'b0;
    s_end  = 1'b0;
    s_word = EndWord;
    if (byte_q == 8'h00) begin
      s_emit = 1'b1;
      s_end  = 1'b1;
    end else if (!byte_q[7]) begin
      s_emit = 1'b1;
      s_word = {8'h00, byte_q};
    end else if (byte_q[7:5] == 3'b110) begin
      s_len = LenTwo;
      s_cp  = {16'h0000, byte_q[4:0]};
    end else if (byte_q[7:4] == 4'b1110) begin
      s_len = LenThree;
      s_cp  = {17'h00000, byte_q[3:0]};
    end else if (byte_q[7:3] == 5'b11110) begin
      s_len = LenFour;
      s_cp  = {18'h00000, byte_q[2:0]};
    end else begin
      // stray continuation or f8..ff
      s_emit = 1'b1;
      s_bad  = 1'b1;
      s_word = ReplacementWord;
    end
  end

  // continuation handling and completion checks
  assign pending   = (len_q >= LenTwo) && (len_q <= LenFour);
  assign is_cont   = (byte_q[7:6] == 2'b10);
  assign cp_new    = {cp_q[CpW-7:0], byte_q[5:0]};
  assign taken_inc = taken_q + 2'd1;
  assign finishing = ({1'b0, taken_inc} + 3'd1) >= len_q;
  assign cp_off    = cp_new - MinFourByte;

  always_comb begin
    case (len_q)
      LenTwo:   seq_bad = cp_new < MinTwoByte;
      LenThree: seq_bad = (cp_new < MinThreeByte) ||
                          ((cp_new >= SurrFirst) && (cp_new <= SurrLast));
      default:  seq_bad = (cp_new < MinFourByte) || (cp_new > MaxCodePoint);
    endcase
  end

  always_comb begin
    len_d   = len_q;
    taken_d = taken_q;
    cp_d    = cp_q;
    bund_d  = '{nbad: '0, ntail: 2'd0, t0_word: s_word, t0_bad: s_bad,
                t0_end: s_end, t1_word: EndWord};
    if (!pending) begin
      len_d        = s_len;
      taken_d      = '0;
      cp_d         = s_cp;
      bund_d.ntail = {1'b0, s_emit};
    end else if (is_cont) begin
      if (finishing) begin
        len_d   = LenNone;
        taken_d = '0;
        cp_d    = '0;
        bund_d.t0_bad = 1'b0;
        bund_d.t0_end = 1'b0;
        if (seq_bad) begin
          // one replacement per byte of the sequence
          bund_d.nbad = len_q;
        end else if ((cp_new == NonCharA) || (cp_new == NonCharB)) begin
          bund_d.nbad = 3'd1;
        end else if (cp_new >= MinFourByte) begin
          bund_d.ntail   = 2'd2;
          bund_d.t0_word = {HighSurrTag, cp_off[19:10]};
          bund_d.t1_word = {LowSurrTag, cp_off[9:0]};
        end else begin
          bund_d.ntail   = 2'd1;
          bund_d.t0_word = cp_new[WordW-1:0];
        end
      end else begin
        taken_d = taken_inc;
        cp_d    = cp_new;
      end
    end else begin
      // missing continuation: replace lead and taken bytes, then restart
      bund_d.nbad  = {1'b0, taken_q} + 3'd1;
      bund_d.ntail = {1'b0, s_emit};
      len_d        = s_len;
      taken_d      = '0;
      cp_d         = s_cp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= LenNone;
      taken_q <= '0;
      cp_q    <= '0;
    end else if (adv) begin
      len_q   <= len_d;
      taken_q <= taken_d;
      cp_q    <= cp_d;
    end
  end

  // result register: words leave one per request
  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    if (adv) begin
      rem_d = bund_d.nbad + {1'b0, bund_d.ntail};
      pos_d = 2'd0;
    end else if (out_take) begin
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      pos_q <= 2'd0;
    end else begin
      rem_q <= rem_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bund_q <= bund_d;
    end
  end

  // word selection: replacements first, then the tail words
  always_comb begin
    utf16_word_o = bund_q.t1_word;
    bad_input_o  = 1'b0;
    string_end_o = 1'b0;
    if ({1'b0, pos_q} < bund_q.nbad) begin
      utf16_word_o = ReplacementWord;
      bad_input_o  = 1'b1;
    end else if ({1'b0, pos_q} == bund_q.nbad) begin
      utf16_word_o = bund_q.t0_word;
      bad_input_o  = bund_q.t0_bad;
      string_end_o = bund_q.t0_end;
    end
  end

  assign out_valid_o    = (rem_q != 3'd0);
  assign last_of_item_o = (rem_q == 3'd1);

endmodule

// ===== rtl/core/u8u16_checker.sv =====
// ----------------------------------------------------------------------------
// u8u16_checker
// port-level checks for the utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [u8u16_pkg::ByteW-1:0]   text_byte_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [u8u16_pkg::WordW-1:0]   utf16_word_o,
  input logic                          bad_input_o,
  input logic                          string_end_o,
  input logic                          last_of_item_o
);
  import u8u16_pkg::*;

  // a stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable(utf16_word_o) && $stable(bad_input_o) &&
      $stable(string_end_o) && $stable(last_of_item_o))
    else $error("stalled result changed");

  // replacements always carry fffd
  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_input_o |-> utf16_word_o == ReplacementWord && !string_end_o)
    else $error("bad_input without replacement word");

  // terminator is a clean zero word and closes its request
  a_end_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> utf16_word_o == EndWord && last_of_item_o)
    else $error("malformed string end");

  // a high surrogate never closes its request, so its low half follows
  a_surr_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bad_input_o && utf16_word_o[15:10] == HighSurrTag |->
      !last_of_item_o)
    else $error("high surrogate ends a request");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);
